// ===== design/lcs_pkg.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// lcs_pkg
// Shared types and codes for the linear contrast stretch core.
// ---------------------------------------------------------------------------
package lcs_pkg;

    localparam int SAMPLE_W = 33;
    localparam int LEVEL_W  = 33;
    localparam int GRAY_W   = 8;
    localparam int SPAN_W   = 33;             // hi - lo when lo < v < hi
    localparam int NUM_W    = SPAN_W + 8;     // (v-lo)*255 + span/2 < 256*span
    localparam int DSH_W    = SPAN_W + 7;     // span shifted to top quotient bit
    localparam int NUM_CELLS = GRAY_W;        // one quotient bit per cell

    // sample format codes
    localparam logic [2:0] FMT_BYTE = 3'd0;
    localparam logic [2:0] FMT_U16  = 3'd1;
    localparam logic [2:0] FMT_S16  = 3'd2;
    localparam logic [2:0] FMT_U32  = 3'd3;
    localparam logic [2:0] FMT_S32  = 3'd4;

    // register indexes
    localparam logic [1:0] REG_FORMAT = 2'd0;
    localparam logic [1:0] REG_LOW    = 2'd1;
    localparam logic [1:0] REG_HIGH   = 2'd2;

    typedef struct packed {
        logic [2:0]                fmt;
        logic signed [LEVEL_W-1:0] low;
        logic signed [LEVEL_W-1:0] high;
    } lcs_cfg_t;

    // item state handed from cell to cell
    typedef struct packed {
        logic              valid;
        logic              forced;      // result known up front
        logic [GRAY_W-1:0] force_gray;
        logic [NUM_W-1:0]  rem;
        logic [DSH_W-1:0]  dsh;
        logic [GRAY_W-1:0] quo;
    } lcs_stage_t;

endpackage
`default_nettype wire

// ===== design/lcs_front.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// lcs_front
// Sample decode, level compare and numerator build (two register stages).
// ---------------------------------------------------------------------------
module lcs_front (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            in_valid,
    input  wire logic [lcs_pkg::SAMPLE_W-1:0]    sample,
    input  wire lcs_pkg::lcs_cfg_t               cfg,
    output lcs_pkg::lcs_stage_t                  stage_out
);
    import lcs_pkg::*;

    typedef struct packed {
        logic              valid;
        logic              forced;
        logic [GRAY_W-1:0] force_gray;
        logic [SPAN_W-1:0] span;
        logic [SPAN_W-1:0] diff;
    } lcs_prep_t;

    lcs_prep_t  prep_reg, prep_next;
    lcs_stage_t stage_reg, stage_next;

    logic signed [LEVEL_W:0] v;
    logic signed [LEVEL_W:0] hi_x;
    logic signed [LEVEL_W:0] lo_x;
    logic signed [LEVEL_W:0] span_x;
    logic signed [LEVEL_W:0] diff_x;
    logic                    fmt_ok;

    // stage A: interpret sample, saturate tests, span and offset
    always_comb
    begin
        v      = '0;
        fmt_ok = 1'b0;
        prep_next = '0;
        case (cfg.fmt)
            FMT_U16:
            begin
                v      = {18'b0, sample[15:0]};
                fmt_ok = 1'b1;
            end
            FMT_S16:
            begin
                v      = {{18{sample[15]}}, sample[15:0]};
                fmt_ok = 1'b1;
            end
            FMT_U32:
            begin
                v      = {2'b0, sample[31:0]};
                fmt_ok = 1'b1;
            end
            FMT_S32:
            begin
                v      = {{2{sample[31]}}, sample[31:0]};
                fmt_ok = 1'b1;
            end
            default:
            begin
                v      = '0;
                fmt_ok = 1'b0;
            end
        endcase

        hi_x   = {cfg.high[LEVEL_W-1], cfg.high};
        lo_x   = {cfg.low[LEVEL_W-1], cfg.low};
        span_x = hi_x - lo_x;
        diff_x = v - lo_x;

        prep_next.valid = in_valid;
        prep_next.span  = span_x[SPAN_W-1:0];
        prep_next.diff  = diff_x[SPAN_W-1:0];
        if (cfg.fmt == FMT_BYTE)
        begin
            prep_next.forced     = 1'b1;
            prep_next.force_gray = sample[7:0];
        end
        else if (!fmt_ok)
        begin
            prep_next.forced     = 1'b1;
            prep_next.force_gray = '0;
        end
        else if (v >= hi_x)
        begin
            prep_next.forced     = 1'b1;
            prep_next.force_gray = '1;
        end
        else if (v <= lo_x)
        begin
            prep_next.forced     = 1'b1;
            prep_next.force_gray = '0;
        end
        else
        begin
            prep_next.forced     = 1'b0;
            prep_next.force_gray = '0;
        end
    end

    // stage B: num = diff*255 + span/2, divisor aligned to quotient bit 7
    always_comb
    begin
        stage_next.valid      = prep_reg.valid;
        stage_next.forced     = prep_reg.forced;
        stage_next.force_gray = prep_reg.force_gray;
        stage_next.rem        = {prep_reg.diff, 8'b0} - {8'b0, prep_reg.diff}
                                + {9'b0, prep_reg.span[SPAN_W-1:1]};
        stage_next.dsh        = {prep_reg.span, 7'b0};
        stage_next.quo        = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prep_reg.valid  <= 1'b0;
            stage_reg.valid <= 1'b0;
        end
        else
        begin
            prep_reg  <= prep_next;
            stage_reg <= stage_next;
        end
    end

    assign stage_out = stage_reg;

endmodule
`default_nettype wire

// ===== design/lcs_div_cell.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// lcs_div_cell
// One restoring-division cell: resolves one quotient bit per item.
// ---------------------------------------------------------------------------
module lcs_div_cell (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire lcs_pkg::lcs_stage_t  stage_in,
    output lcs_pkg::lcs_stage_t       stage_out
);
    import lcs_pkg::*;

    lcs_stage_t stage_reg, stage_next;
    logic       take;

    always_comb
    begin
        take       = stage_in.rem >= {1'b0, stage_in.dsh};
        stage_next = stage_in;
        if (take)
        begin
            stage_next.rem = stage_in.rem - {1'b0, stage_in.dsh};
        end
        stage_next.quo = {stage_in.quo[GRAY_W-2:0], take};
        stage_next.dsh = stage_in.dsh >> 1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_reg.valid <= 1'b0;
        end
        else
        begin
            stage_reg <= stage_next;
        end
    end

    assign stage_out = stage_reg;

endmodule
`default_nettype wire

// ===== design/linear_contrast_stretch_core.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// linear_contrast_stretch_core
// Maps one raster sample to an 8-bit gray level by linear stretch.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel: drive sample and pulse start; an item is taken at any
//   edge with start high and busy low. busy is always low, so one item
//   can enter every clock.
//   Result channel: gray is valid for the single cycle that done is high.
//   The receiver cannot stall; results are never held.
//   Config: cfg_we/cfg_index/cfg_data write sample_format (0), low_level (1)
//   and high_level (2); write only while no item is in flight.
//   Throughput: one item per clock.
//   Pipeline: two front stages (decode/compare, numerator build), a chain
//   of eight division cells, one quotient bit each, and an output register.
//   Saturated, byte and unused-format items ride the chain with a forced
//   result and skip the quotient.
//   Reset: clears all valid bits and loads format 1 (unsigned 16),
//   low 0, high 65535; items in flight are dropped.
// ---------------------------------------------------------------------------
module linear_contrast_stretch_core (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           start,
    output      logic                           busy,
    input  wire logic [lcs_pkg::SAMPLE_W-1:0]   sample,
    output      logic                           done,
    output      logic [lcs_pkg::GRAY_W-1:0]     gray,
    input  wire logic                           cfg_we,
    input  wire logic [1:0]                     cfg_index,
    input  wire logic [lcs_pkg::LEVEL_W-1:0]    cfg_data
);
    import lcs_pkg::*;

    lcs_cfg_t   cfg_reg;
    lcs_stage_t chain [0:NUM_CELLS];

    logic              done_reg, done_next;
    logic [GRAY_W-1:0] gray_reg, gray_next;

    // config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.fmt  <= FMT_U16;
            cfg_reg.low  <= '0;
            cfg_reg.high <= LEVEL_W'(65535);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_FORMAT: cfg_reg.fmt  <= cfg_data[2:0];
                REG_LOW:    cfg_reg.low  <= cfg_data;
                REG_HIGH:   cfg_reg.high <= cfg_data;
                default:    ;   // no register at this index
            endcase
        end
    end

    assign busy = 1'b0;

    lcs_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (start),
        .sample    (sample),
        .cfg       (cfg_reg),
        .stage_out (chain[0])
    );

    // divider chain, MSB of the quotient first
    for (genvar i = 0; i < NUM_CELLS; i++)
    begin : g_cell
        lcs_div_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .stage_in  (chain[i]),
            .stage_out (chain[i+1])
        );
    end

    // output register
    always_comb
    begin
        done_next = chain[NUM_CELLS].valid;
        gray_next = chain[NUM_CELLS].forced ? chain[NUM_CELLS].force_gray
                                            : chain[NUM_CELLS].quo;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        gray_reg <= gray_next;
    end

    assign done = done_reg;
    assign gray = gray_reg;

`ifndef SYNTHESIS
    // every accepted item comes out of the pipeline with a done pulse
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##11 done)
        else $error("item lost in pipeline");

    // an item that needs the divider always has a nonzero divisor
    a_divisor: assert property (@(posedge clk) disable iff (!rst_n)
        (chain[0].valid && !chain[0].forced) |-> (chain[0].dsh != '0))
        else $error("zero divisor entered divider chain");

    // the forced flag is carried unchanged along the chain
    a_forced_kept: assert property (@(posedge clk) disable iff (!rst_n)
        chain[NUM_CELLS].valid |-> (chain[NUM_CELLS].forced
                                    == $past(chain[NUM_CELLS-1].forced)))
        else $error("forced flag changed in divider cell");
`endif

endmodule
`default_nettype wire

// ===== sim/linear_contrast_stretch_core_tb.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// linear_contrast_stretch_core_tb
// Self-checking bench for the linear contrast stretch core.
// Samples go in through the start/busy port. A small tracker keeps its own
// copy of the three registers and works out the gray level of every
// accepted item. Each done pulse is checked against the oldest pending gray.
// A directed pass covers the format corners, the saturation and equal or
// crossed levels, and the unused format codes. Random phases follow, each
// with a fresh register setting and its own pacing.
// ---------------------------------------------------------------------------
import lcs_pkg::*;

class gray_tracker;
    lcs_cfg_t   regs;
    logic [7:0] pending_gray[$];
    int         failures;

    function new();
        regs.fmt  = FMT_U16;
        regs.low  = '0;
        regs.high = 33'sd65535;
        failures  = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [LEVEL_W-1:0] data);
        case (idx)
            REG_FORMAT: regs.fmt = data[2:0];
            REG_LOW:    regs.low = data;
            REG_HIGH:   regs.high = data;
            default: ;
        endcase
    endfunction

    // gray level for one raw sample under the current registers
    function logic [7:0] stretch_gray(logic [SAMPLE_W-1:0] s);
        longint v;
        longint lo;
        longint hi;
        longint span;
        longint num;
        lo = longint'($signed(regs.low));
        hi = longint'($signed(regs.high));
        case (regs.fmt)
            FMT_BYTE: return s[7:0];
            FMT_U16:  v = longint'(s[15:0]);
            FMT_S16:  v = longint'($signed(s[15:0]));
            FMT_U32:  v = longint'(s[31:0]);
            FMT_S32:  v = longint'($signed(s[31:0]));
            default:  return 8'd0;
        endcase
        // high test first: crossed or equal levels never divide
        if (v >= hi)
            return 8'd255;
        if (v <= lo)
            return 8'd0;
        span = hi - lo;
        num  = (v - lo) * 255 + span / 2;
        return 8'(num / span);
    endfunction

    function void note_sample(logic [SAMPLE_W-1:0] s);
        pending_gray.push_back(stretch_gray(s));
    endfunction

    function void check_gray(logic [7:0] g);
        logic [7:0] want;
        if (pending_gray.size() == 0)
        begin
            $display("%0t: gray with no item pending, expected none, actual %0d",
                     $time, g);
            failures++;
            return;
        end
        want = pending_gray.pop_front();
        if (g !== want)
        begin
            $display("%0t: gray mismatch, expected %0d, actual %0d", $time, want, g);
            failures++;
        end
    endfunction

    function int pending();
        return pending_gray.size();
    endfunction
endclass

module linear_contrast_stretch_core_tb;

    // drain wait: the trip through the core, plus margin
    localparam int     LATENCY_WAIT = 16;
    // limit well above the slowest run (about 1450 items at the widest gaps, plus drains)
    localparam int     CYCLE_LIMIT  = 150000;
    localparam longint S32_MIN      = -64'sd2147483648;
    localparam longint S32_MAX      = 64'sd2147483647;
    localparam longint U32_MAX      = 64'sd4294967295;

    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                start     = 1'b0;
    logic                busy;
    logic [SAMPLE_W-1:0] sample    = '0;
    logic                done;
    logic [GRAY_W-1:0]   gray;
    logic                cfg_we    = 1'b0;
    logic [1:0]          cfg_index = REG_FORMAT;
    logic [LEVEL_W-1:0]  cfg_data  = '0;

    int          cycle_count = 0;
    gray_tracker tracker;

    linear_contrast_stretch_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .sample    (sample),
        .done      (done),
        .gray      (gray),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    // -----------------------------------------------------------------------
    // Monitor. Everything is sampled at the rising edge, before the
    // nonblocking updates of that edge land, so the tracker sees exactly
    // what the core sees. The result is checked before the new item is
    // noted; the core registers every item, so the two can never refer to the
    // same item. Register writes update the tracker at the edge that takes them.
    // -----------------------------------------------------------------------
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
        else if (rst_n)
        begin
            if (done === 1'b1)
                tracker.check_gray(gray);
            if (cfg_we === 1'b1)
                tracker.write_reg(cfg_index, cfg_data);
            if (start === 1'b1 && busy === 1'b0)
                tracker.note_sample(sample);
        end
    end

    // -----------------------------------------------------------------------
    // Range helpers per format; the unused codes take the full level range.
    // -----------------------------------------------------------------------
    function automatic longint fmt_min(logic [2:0] f);
        case (f)
            FMT_U16, FMT_U32: return 0;
            FMT_S16:          return -32768;
            default:          return S32_MIN;
        endcase
    endfunction

    function automatic longint fmt_max(logic [2:0] f);
        case (f)
            FMT_U16: return 65535;
            FMT_S16: return 32767;
            FMT_S32: return S32_MAX;
            default: return U32_MAX;
        endcase
    endfunction

    function automatic int fmt_bits(logic [2:0] f);
        case (f)
            FMT_BYTE:         return 8;
            FMT_U16, FMT_S16: return 16;
            default:          return 32;
        endcase
    endfunction

    // uniform in [a, b], a <= b, spans up to 2^33
    function automatic longint rand_between(longint a, longint b);
        longint unsigned r;
        r = {$urandom, $urandom};
        return a + longint'(r % (b - a + 1));
    endfunction

    // mostly real formats; the unused codes now and then
    function automatic logic [2:0] pick_format();
        if ($urandom_range(0, 9) == 0)
            return 3'($urandom_range(5, 7));
        return 3'($urandom_range(FMT_BYTE, FMT_S32));
    endfunction

    function automatic longint pick_level(logic [2:0] f);
        case ($urandom_range(0, 5))
            0:
            begin
                case ($urandom_range(0, 5))
                    0:       return S32_MIN;
                    1:       return U32_MAX;
                    2:       return 0;
                    3:       return -1;
                    4:       return fmt_min(f);
                    default: return fmt_max(f);
                endcase
            end
            1:       return rand_between(S32_MIN, U32_MAX);
            default: return rand_between(fmt_min(f), fmt_max(f));
        endcase
    endfunction

    // Most samples land between or right at the levels; the rest is raw
    // noise or format extremes. Bits above the format width stay random.
    function automatic logic [SAMPLE_W-1:0] pick_sample(logic [2:0] f, longint lo,
                                                        longint hi);
        logic [SAMPLE_W-1:0] raw;
        logic [63:0]         mask;
        longint              v;
        longint              a;
        longint              b;
        raw[31:0] = $urandom;
        raw[32]   = 1'($urandom_range(0, 1));
        a = (lo > fmt_min(f)) ? lo : fmt_min(f);
        b = (hi < fmt_max(f)) ? hi : fmt_max(f);
        case ($urandom_range(0, 9))
            0, 1: return raw;
            2:    v = $urandom_range(0, 1) ? fmt_min(f) : fmt_max(f);
            3:    v = lo + rand_between(-2, 2);
            4:    v = hi + rand_between(-2, 2);
            default:
            begin
                if (a < b)
                    v = rand_between(a, b);
                else
                    v = rand_between(fmt_min(f), fmt_max(f));
            end
        endcase
        mask = (64'd1 << fmt_bits(f)) - 64'd1;
        return SAMPLE_W'((64'(raw) & ~mask) | (64'(v) & mask));
    endfunction

    // pacing: 0 back-to-back, 1 any gap, 2 mostly back-to-back
    function automatic int next_gap(int mode);
        case (mode)
            0:       return 0;
            1:       return $urandom_range(0, 14);
            default: return ($urandom_range(0, 3) == 0) ? $urandom_range(1, 14) : 0;
        endcase
    endfunction

    // -----------------------------------------------------------------------
    // Drivers. start is only touched once per edge: it stays high across
    // back-to-back items and is dropped only when a gap follows.
    // -----------------------------------------------------------------------
    task automatic feed(input logic [SAMPLE_W-1:0] s, input int gap);
        start  <= 1'b1;
        sample <= s;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // stop sending and let every pending gray come out of the pipe
    task automatic wait_idle();
        start <= 1'b0;
        while (tracker.pending() != 0)
            @(posedge clk);
        repeat (LATENCY_WAIT) @(posedge clk);
    endtask

    // registers change only with the pipe empty; all three written in a row
    task automatic load_config(input logic [2:0] f, input longint lo, input longint hi);
        wait_idle();
        cfg_we    <= 1'b1;
        cfg_index <= REG_FORMAT;
        cfg_data  <= LEVEL_W'(f);
        @(posedge clk);
        cfg_index <= REG_LOW;
        cfg_data  <= lo[LEVEL_W-1:0];
        @(posedge clk);
        cfg_index <= REG_HIGH;
        cfg_data  <= hi[LEVEL_W-1:0];
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // one random register setting followed by a burst of items
    task automatic random_phase(input int count);
        logic [2:0] f;
        longint     lo;
        longint     hi;
        longint     t;
        int         mode;
        f  = pick_format();
        lo = pick_level(f);
        hi = pick_level(f);
        case ($urandom_range(0, 9))
            6:
            begin
                // narrow span: a handful of in-between codes
                hi = lo + rand_between(1, 3);
                if (hi > U32_MAX)
                    hi = U32_MAX;
            end
            7: hi = lo;
            8:
            begin
                // crossed levels
                if (lo < hi)
                begin
                    t  = lo;
                    lo = hi;
                    hi = t;
                end
            end
            9: ;
            default:
            begin
                if (lo > hi)
                begin
                    t  = lo;
                    lo = hi;
                    hi = t;
                end
            end
        endcase
        load_config(f, lo, hi);
        mode = $urandom_range(0, 2);
        for (int i = 0; i < count; i++)
        begin
            // rare full drain in the middle of a burst
            if ($urandom_range(0, 149) == 0)
            begin
                feed(pick_sample(f, lo, hi), 0);
                wait_idle();
            end
            else
                feed(pick_sample(f, lo, hi), next_gap(mode));
        end
    endtask

    initial
    begin
        tracker = new();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset setting: unsigned 16, 0 .. 65535; upper bits must be ignored
        feed(33'h0_0000_0000, $urandom_range(0, 2));
        feed(33'h0_0000_FFFF, $urandom_range(0, 2));
        feed(33'h0_0000_7FFF, $urandom_range(0, 2));
        feed(33'h1_FFFF_0001, $urandom_range(0, 2));

        // byte passthrough
        load_config(FMT_BYTE, 0, 65535);
        feed(33'h1_FFFF_FFAB, $urandom_range(0, 2));
        feed(33'h0_0000_0000, $urandom_range(0, 2));
        feed(33'h0_0000_00FF, $urandom_range(0, 2));

        // signed 16 around zero: both rails, -1 and just below high
        load_config(FMT_S16, -100, 100);
        feed(33'h0_0000_8000, $urandom_range(0, 2));
        feed(33'h0_0000_7FFF, $urandom_range(0, 2));
        feed(33'h1_FFFF_FFFF, $urandom_range(0, 2));
        feed(33'h0_0000_0063, $urandom_range(0, 2));

        // unsigned 32 over the full range
        load_config(FMT_U32, 0, U32_MAX);
        feed(33'h0_FFFF_FFFF, $urandom_range(0, 2));
        feed(33'h1_8000_0000, $urandom_range(0, 2));
        feed(33'h0_0000_0001, $urandom_range(0, 2));

        // signed 32 with low at the signed 32 minimum and high at the unsigned 32 maximum
        load_config(FMT_S32, S32_MIN, U32_MAX);
        feed(33'h0_8000_0000, $urandom_range(0, 2));
        feed(33'h1_7FFF_FFFF, $urandom_range(0, 2));
        feed(33'h0_0000_0000, $urandom_range(0, 2));

        // equal levels
        load_config(FMT_U16, 500, 500);
        feed(33'd500, $urandom_range(0, 2));
        feed(33'd499, $urandom_range(0, 2));

        // levels outside the format range
        load_config(FMT_U16, -1000, 100000);
        feed(33'h0_0000_FFFF, $urandom_range(0, 2));
        feed(33'h1_0000_0000, $urandom_range(0, 2));

        // crossed levels: anything at or above high saturates
        load_config(FMT_S16, 200, -200);
        feed(33'd150, $urandom_range(0, 2));

        // unused format codes always give zero
        load_config(3'd5, 0, 255);
        feed(33'h1_FFFF_FFFF, $urandom_range(0, 2));
        load_config(3'd7, S32_MIN, U32_MAX);
        feed(33'h0_1234_5678, $urandom_range(0, 2));

        for (int p = 0; p < 11; p++)
            random_phase($urandom_range(70, 130));

        wait_idle();
        if (tracker.failures == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// ===== filelist.f =====
design/lcs_pkg.sv
design/lcs_front.sv
design/lcs_div_cell.sv
design/linear_contrast_stretch_core.sv
sim/linear_contrast_stretch_core_tb.sv
